/* rtl/rdf_pkg.sv */
// Shared constants, widths and the digit-to-ASCII function of the radix digit formatter.
`timescale 1ns / 1ps
package rdf_pkg;

	localparam int VALUE_BITS = 32;
	localparam int DATA_W     = ((VALUE_BITS + 7) / 8) * 8;
	localparam int RADIX_W    = 6;
	localparam int USER_W     = RADIX_W + 1;
	localparam int CHAR_W     = 8;
	localparam int DIGIT_W    = 6;

	// digit store: one entry per digit, least significant first
	localparam int ADDR_W = $clog2(VALUE_BITS);
	localparam int CNT_W  = $clog2(VALUE_BITS + 1);

	// divider retires DIV_STEP quotient bits per cycle while a division runs
	localparam int DIV_STEP = 4;
	localparam int DIV_CYC  = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
	localparam int DIV_W    = DIV_CYC * DIV_STEP;
	localparam int DCNT_W   = $clog2(DIV_CYC + 1);

	localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_DEFAULT = 6'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] TEN        = 8'd10;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
			input logic upper);
		logic [CHAR_W-1:0] dx;
		dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
		if (dx < TEN) begin
			digit_char = CHAR_ZERO + dx;
		end else if (upper) begin
			digit_char = CHAR_UPPER + dx - TEN;
		end else begin
			digit_char = CHAR_LOWER + dx - TEN;
		end
	endfunction

endpackage

/* rtl/rdf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/rdf_divider.sv */
// Shared iterative divider: magnitude by base, DIV_STEP quotient bits per cycle while busy.
`timescale 1ns / 1ps
module rdf_divider (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [rdf_pkg::VALUE_BITS-1:0]   dividend,
	input  logic [rdf_pkg::RADIX_W-1:0]      divisor,
	output logic                             done,
	output logic [rdf_pkg::VALUE_BITS-1:0]   quotient,
	output logic [rdf_pkg::DIGIT_W-1:0]      remainder
);

	logic [rdf_pkg::DIV_W-1:0]   dvd_q;
	logic [rdf_pkg::DIGIT_W-1:0] rem_q;
	logic [rdf_pkg::RADIX_W-1:0] div_q;
	logic [rdf_pkg::DCNT_W-1:0]  cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic [rdf_pkg::DIV_W-1:0]   dvd_nxt;
	logic [rdf_pkg::DIGIT_W-1:0] rem_nxt;

	// restoring steps: partial remainder stays below the divisor, so 6 bits hold it
	always_comb begin
		logic [rdf_pkg::DIGIT_W:0] t;
		dvd_nxt = dvd_q;
		rem_nxt = rem_q;
		for (int i = 0; i < rdf_pkg::DIV_STEP; i++) begin
			t       = {rem_nxt, dvd_nxt[rdf_pkg::DIV_W-1]};
			dvd_nxt = {dvd_nxt[rdf_pkg::DIV_W-2:0], 1'b0};
			if (t >= {1'b0, div_q}) begin
				t          = t - {1'b0, div_q};
				dvd_nxt[0] = 1'b1;
			end
			rem_nxt = t[rdf_pkg::DIGIT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == rdf_pkg::DCNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= rdf_pkg::DCNT_W'(rdf_pkg::DIV_CYC);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == rdf_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= rdf_pkg::DIV_W'(dividend);
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= dvd_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q[rdf_pkg::VALUE_BITS-1:0];
	assign remainder = rem_q;

`ifndef SYNTH
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q))
		else $error("divider done without a running division");
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ({1'b0, remainder} < {1'b0, div_q}))
		else $error("divider remainder not below divisor");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start)
		else $error("divider started while busy");
`endif

endmodule

/* rtl/radix_digit_formatter.sv */
// Top level: signed integer to ASCII digits in base 2..36, one character per beat.
//
//  channel | dir | tdata                        | tuser                          | tlast
//  s_*     | in  | [31:0] value (signed)        | [5:0] radix, [6] upper_case    | -
//  m_*     | out | [7:0] character              | -                              | last
//
// Each digit takes one division of the magnitude by the base in the shared divider; each
// character is then read back through the digit store read port (ST_READ, then ST_EMIT).
// s_tready is high only while the sequencer is idle; the output register may still hold
// the last beat of the previous run. Reset is asynchronous and clears only control state.
// A stalled output holds the sequencer in place; no beats are dropped.
`timescale 1ns / 1ps
module radix_digit_formatter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [rdf_pkg::DATA_W-1:0]     s_tdata,  // [VALUE_BITS-1:0] value
	input  logic [rdf_pkg::USER_W-1:0]     s_tuser,  // [5:0] radix, [6] upper_case
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [rdf_pkg::CHAR_W-1:0]     m_tdata,  // [7:0] character
	output logic                           m_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_SIGN,
		ST_READ,
		ST_EMIT
	} state_t;

	state_t                           state_q;
	logic [rdf_pkg::VALUE_BITS-1:0]   mag_q;
	logic [rdf_pkg::RADIX_W-1:0]      base_q;
	logic                             upper_q;
	logic                             neg_q;
	logic [rdf_pkg::CNT_W-1:0]        nd_q;
	logic                             start_q;
	logic                             m_tvalid_q;
	logic [rdf_pkg::CHAR_W-1:0]       m_tdata_q;
	logic                             m_tlast_q;

	logic [rdf_pkg::VALUE_BITS-1:0]   in_value;
	logic [rdf_pkg::RADIX_W-1:0]      in_radix;
	logic                             in_neg;
	logic                             out_free;
	logic                             beat_load;
	logic                             div_done;
	logic [rdf_pkg::VALUE_BITS-1:0]   div_quot;
	logic [rdf_pkg::DIGIT_W-1:0]      div_rem;
	logic                             ram_we;
	logic [rdf_pkg::ADDR_W-1:0]       ram_raddr;
	logic [rdf_pkg::CNT_W-1:0]        nd_dec;
	logic [rdf_pkg::DIGIT_W-1:0]      ram_rdata;

	assign in_value = s_tdata[rdf_pkg::VALUE_BITS-1:0];
	assign in_radix = s_tuser[rdf_pkg::RADIX_W-1:0];
	assign in_neg   = in_value[rdf_pkg::VALUE_BITS-1];
	assign out_free = !m_tvalid_q || m_tready;
	assign beat_load = ((state_q == ST_SIGN) && neg_q && out_free) ||
		((state_q == ST_EMIT) && out_free);
	assign ram_we   = (state_q == ST_DIVIDE) && div_done;
	assign nd_dec   = nd_q - 1'b1;
	assign ram_raddr = nd_dec[rdf_pkg::ADDR_W-1:0];

	rdf_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.dividend  (mag_q),
		.divisor   (base_q),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// digits are stored least significant first and read back from the top
	rdf_ram #(
		.WIDTH (rdf_pkg::DIGIT_W),
		.DEPTH (rdf_pkg::VALUE_BITS)
	) u_digits (
		.clk   (clk),
		.we    (ram_we),
		.waddr (nd_q[rdf_pkg::ADDR_W-1:0]),
		.wdata (div_rem),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			nd_q       <= '0;
			start_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			start_q    <= ((state_q == ST_IDLE) && s_tvalid) ||
				((state_q == ST_DIVIDE) && div_done && (div_quot != '0));
			m_tvalid_q <= beat_load || (m_tvalid_q && !m_tready);
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						nd_q    <= '0;
						state_q <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					if (div_done) begin
						nd_q <= nd_q + 1'b1;
						// zero still yields one digit: the loop runs at least once
						if (div_quot == '0) begin
							state_q <= ST_SIGN;
						end
					end
				end
				ST_SIGN: begin
					if (!neg_q || out_free) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						nd_q <= nd_dec;
						if (nd_q == rdf_pkg::CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			mag_q   <= in_neg ? (~in_value + 1'b1) : in_value;
			upper_q <= s_tuser[rdf_pkg::RADIX_W];
			neg_q   <= in_neg;
			if (in_radix < rdf_pkg::RADIX_MIN || in_radix > rdf_pkg::RADIX_MAX) begin
				base_q <= rdf_pkg::RADIX_DEFAULT;
			end else begin
				base_q <= in_radix;
			end
		end else if (state_q == ST_DIVIDE && div_done) begin
			mag_q <= div_quot;
		end
		if (state_q == ST_SIGN && neg_q && out_free) begin
			m_tdata_q <= rdf_pkg::CHAR_MINUS;
			m_tlast_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			m_tdata_q <= rdf_pkg::digit_char(ram_rdata, upper_q);
			m_tlast_q <= (nd_q == rdf_pkg::CNT_W'(1));
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("accepted a second item without finishing the run");
	a_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		nd_q <= rdf_pkg::CNT_W'(rdf_pkg::VALUE_BITS))
		else $error("digit count beyond value width");
	a_start_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> (state_q == ST_DIVIDE))
		else $error("divider started outside the divide phase");
	a_emit_has_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT || state_q == ST_READ) |-> (nd_q != '0))
		else $error("reading digits with an empty store");
`endif

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for radix_digit_formatter: numbers in, predicted ASCII runs out.
`timescale 1ns / 1ps
module tb_top;

	typedef struct packed {
		logic [rdf_pkg::CHAR_W-1:0] ch;
		logic                       last;
	} out_beat_t;

	localparam int TAIL_CYCLES = 450;

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [rdf_pkg::DATA_W-1:0]    s_tdata  = '0;  // [31:0] value
	logic [rdf_pkg::USER_W-1:0]    s_tuser  = '0;  // [5:0] radix, [6] upper_case
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [rdf_pkg::CHAR_W-1:0]    m_tdata;        // [7:0] character
	logic                          m_tlast;

	out_beat_t   char_q[$];
	int          err_cnt      = 0;
	int          n_numbers    = 0;
	int          n_chars      = 0;
	int          n_negative   = 0;
	int          n_fallback   = 0;
	int          longest_run  = 0;
	int          long_holds   = 0;
	int unsigned hold_req     = 0;
	bit          tx_idle_en   = 1'b1;
	bit          rx_idle_en   = 1'b1;

	radix_digit_formatter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#40_000_000;
		$display("tb_top: timeout with %0d characters still expected", char_q.size());
		$display("tb_top: FAIL");
		$finish;
	end

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 60);
	endfunction

	// expected characters of one number, most significant digit first
	function automatic void format_digits(input logic [rdf_pkg::VALUE_BITS-1:0] value,
			input logic [rdf_pkg::RADIX_W-1:0] radix, input logic upper);
		logic [rdf_pkg::VALUE_BITS-1:0] mag;
		logic [rdf_pkg::VALUE_BITS-1:0] base;
		logic [rdf_pkg::VALUE_BITS-1:0] d;
		logic [rdf_pkg::CHAR_W-1:0]     digit_q[$];
		logic [rdf_pkg::CHAR_W-1:0]     ch;
		logic                           neg;
		out_beat_t                      beat;
		if (radix < rdf_pkg::RADIX_MIN || radix > rdf_pkg::RADIX_MAX) begin
			base = rdf_pkg::VALUE_BITS'(rdf_pkg::RADIX_DEFAULT);
			n_fallback++;
		end else begin
			base = rdf_pkg::VALUE_BITS'(radix);
		end
		neg = value[rdf_pkg::VALUE_BITS-1];
		mag = neg ? -value : value;   // most negative value wraps to its own magnitude
		n_numbers++;
		if (mag == '0) begin
			beat.ch   = rdf_pkg::CHAR_ZERO;
			beat.last = 1'b1;
			char_q.push_back(beat);
			if (longest_run < 1) longest_run = 1;
			return;
		end
		while (mag != '0) begin
			d = mag % base;
			if (d < 10) begin
				ch = rdf_pkg::CHAR_ZERO + rdf_pkg::CHAR_W'(d);
			end else if (upper) begin
				ch = rdf_pkg::CHAR_UPPER + rdf_pkg::CHAR_W'(d - 10);
			end else begin
				ch = rdf_pkg::CHAR_LOWER + rdf_pkg::CHAR_W'(d - 10);
			end
			digit_q.push_front(ch);
			mag = mag / base;
		end
		if (neg) begin
			beat.ch   = rdf_pkg::CHAR_MINUS;
			beat.last = 1'b0;
			char_q.push_back(beat);
			n_negative++;
		end
		foreach (digit_q[i]) begin
			beat.ch   = digit_q[i];
			beat.last = (i == digit_q.size() - 1);
			char_q.push_back(beat);
		end
		if (longest_run < digit_q.size() + neg) longest_run = digit_q.size() + neg;
	endfunction

	// offer one number, wait for the beat, then maybe idle
	task automatic send_number(input logic [rdf_pkg::VALUE_BITS-1:0] value,
			input logic [rdf_pkg::RADIX_W-1:0] radix, input logic upper);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tdata  <= rdf_pkg::DATA_W'(value);
		s_tuser  <= {upper, radix};
		do begin
			@(posedge clk);
		end while (!s_tready);
		format_digits(value, radix, upper);
		gap = tx_idle_en ? pick_gap() : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random_number();
		logic [rdf_pkg::VALUE_BITS-1:0] value;
		logic [rdf_pkg::RADIX_W-1:0]    radix;
		int unsigned                    r;
		r = $urandom_range(0, 9);
		case (r)
			0, 1, 2, 3: begin
				value = $urandom;
			end
			4: begin
				value = $urandom_range(0, 40);
			end
			5: begin
				value = -$urandom_range(1, 40);
			end
			6: begin
				case ($urandom_range(0, 5))
					0: value = 32'h8000_0000;
					1: value = 32'h7fff_ffff;
					2: value = 32'hffff_ffff;
					3: value = 32'h8000_0001;
					4: value = 32'h0000_0001;
					default: value = '0;
				endcase
			end
			default: begin
				value = $urandom >> $urandom_range(0, 31);
				if ($urandom_range(0, 1)) value = -value;
			end
		endcase
		if ($urandom_range(0, 99) < 85) begin
			radix = rdf_pkg::RADIX_W'($urandom_range(rdf_pkg::RADIX_MIN, rdf_pkg::RADIX_MAX));
		end else begin
			radix = rdf_pkg::RADIX_W'($urandom_range(0, 63));
		end
		send_number(value, radix, 1'($urandom_range(0, 1)));
	endtask

	// sender stops until every expected character is out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (char_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		send_number(0, 10, 1'b0);
		send_number(0, 2, 1'b1);
		send_number(32'h8000_0000, 2, 1'b0);   // longest run: sign and 32 digits
		send_number(32'h7fff_ffff, 2, 1'b0);
		send_number(32'h8000_0000, 10, 1'b0);
		send_number(32'h7fff_ffff, 36, 1'b1);
		send_number(32'hffff_ffff, 16, 1'b0);
		send_number(35, 36, 1'b0);
		send_number(35, 36, 1'b1);
		send_number(36, 36, 1'b0);
		send_number(-123456789, 36, 1'b1);
		send_number(255, 16, 1'b1);
		send_number(255, 16, 1'b0);
		send_number(-77, 0, 1'b0);              // bases outside 2..36 fall back to decimal
		send_number(-77, 1, 1'b1);
		send_number(4096, 37, 1'b0);
		send_number(32'h8000_0000, 63, 1'b1);
		send_number(1, 2, 1'b0);
		send_number(12345, 3, 1'b1);
		send_number(-2, 7, 1'b0);
		send_number(32'hdead_beef, 16, 1'b1);
		send_number(1000, 10, 1'b0);
		wait_drained();
	endtask

	// output stalls long enough for the block to refuse new input
	task automatic test_backpressure();
		tx_idle_en = 1'b0;
		hold_req   = 400;
		repeat (10) send_random_number();
		tx_idle_en = 1'b1;
		wait_drained();
	endtask

	task automatic test_no_idle();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		repeat (30) send_random_number();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	task automatic test_random();
		for (int i = 0; i < 360; i++) begin
			send_random_number();
			if (i % 60 == 59) wait_drained();
		end
	endtask

	initial begin
		int unsigned rx_wait;
		rx_wait = 0;
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				rx_wait  = hold_req;
				hold_req = 0;
				long_holds++;
			end
			if (!arst_n) begin
				m_tready <= 1'b0;
			end else if (rx_wait != 0) begin
				m_tready <= 1'b0;
				rx_wait--;
			end else begin
				m_tready <= 1'b1;
				if (rx_idle_en && $urandom_range(0, 3) == 0) rx_wait = pick_gap();
			end
		end
	end

	task automatic note_mismatch(input string what, input out_beat_t want,
			input out_beat_t got);
		err_cnt++;
		if (err_cnt <= 10) begin
			$display("tb_top: %s at %0t: expected char %h last %b, got char %h last %b",
				what, $realtime, want.ch, want.last, got.ch, got.last);
		end
	endtask

	always @(posedge clk) begin
		out_beat_t got;
		out_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.ch   = m_tdata;
			got.last = m_tlast;
			n_chars++;
			if (char_q.size() == 0) begin
				want = '0;
				note_mismatch("unexpected beat", want, got);
			end else begin
				want = char_q.pop_front();
				if (got.ch !== want.ch || got.last !== want.last) begin
					note_mismatch("mismatch", want, got);
				end
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_no_idle();
		test_random();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("tb_top: %0d numbers, %0d characters, %0d negative, %0d decimal fallbacks",
			n_numbers, n_chars, n_negative, n_fallback);
		$display("tb_top: longest run %0d characters, %0d long output stalls, %0d errors",
			longest_run, long_holds, err_cnt);
		if (err_cnt == 0 && char_q.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
